// File: rtl/rgbdim_pkg.sv
`default_nettype none

package rgbdim_pkg;

   localparam int unsigned LevelWidth = 8;
   localparam int unsigned NumColours = 3;
   localparam int unsigned NumLines   = 5;

   localparam logic [LevelWidth-1:0] LevelDark = 8'd255;
   localparam logic [LevelWidth-1:0] StepReset = 8'd15;

   // press line positions in press_seen
   localparam int unsigned LineRed   = 0;
   localparam int unsigned LineGreen = 1;
   localparam int unsigned LineBlue  = 2;
   localparam int unsigned LineOff   = 3;
   localparam int unsigned LineKnob  = 4;

   // press_seen after reset: knob press line seen high
   localparam logic [NumLines-1:0] SeenReset = 5'b10000;

   typedef enum logic [1:0] {
      COLOUR_NONE  = 2'd0,
      COLOUR_RED   = 2'd1,
      COLOUR_GREEN = 2'd2,
      COLOUR_BLUE  = 2'd3
   } colour_type;

   typedef struct packed {
      logic red_press;
      logic green_press;
      logic blue_press;
      logic off_press;
      logic knob_press;
      logic enc_clk;
      logic enc_dat;
   } req_type;

   typedef struct packed {
      logic [LevelWidth-1:0] red_level;
      logic [LevelWidth-1:0] green_level;
      logic [LevelWidth-1:0] blue_level;
      colour_type            chosen_colour;
      logic                  knob_armed;
      logic                  updated;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/rgbdim_chan_if.sv
`default_nettype none

interface rgbdim_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/rgb_encoder_dimmer_control.sv
// Channel   Direction  Handshake      Carries
// req_chan  in         valid/ready    press lines, encoder clock and data pins
// rsp_chan  out        valid/ready    three levels, colour, armed, updated
// csr       in         csr_we         dim_step
//
// One request per cycle while req_chan.ready is high; each result appears in the cycle after its request.
// All tracking state and the result register update on the same edge.
// req_chan.ready is low only while a result is held and rsp_chan.ready is low.
// Reset (synchronous): levels dark, nothing selected, disarmed, dim_step 15.
`default_nettype none

module rgb_encoder_dimmer_control
   import rgbdim_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   rgbdim_chan_if.sink        req_chan,
   rgbdim_chan_if.source      rsp_chan,
   input  wire logic          csr_we,
   input  wire logic [LevelWidth-1:0] csr_wdata
);

   logic [LevelWidth-1:0]                  step_ff;
   logic [NumColours-1:0][LevelWidth-1:0]  level_ff,  level_in;
   colour_type                             sel_ff,    sel_in;
   logic                                   armed_ff,  armed_in;
   logic [NumLines-1:0]                    seen_ff,   seen_in;
   logic                                   pclk_ff,   pclk_in;
   logic                                   pdat_ff,   pdat_in;
   logic                                   pend_ff,   pend_in;
   logic                                   rvalid_ff;
   rsp_type                                rsp_ff,    rsp_in;

   logic                  accept;
   logic [NumLines-1:0]   line;
   logic                  colour_diff;
   logic [1:0]            idx;
   logic [LevelWidth-1:0] cur;
   logic [LevelWidth:0]   sum;
   logic [LevelWidth-1:0] moved;
   logic                  upd;

   assign req_chan.ready   = !rvalid_ff || rsp_chan.ready;
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rvalid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign line = {req_chan.payload.knob_press, req_chan.payload.off_press,
                  req_chan.payload.blue_press, req_chan.payload.green_press,
                  req_chan.payload.red_press};
   assign colour_diff = (line[LineBlue:LineRed] != seen_ff[LineBlue:LineRed]);

   always_comb begin
      level_in = level_ff;
      sel_in   = sel_ff;
      armed_in = armed_ff;
      seen_in  = seen_ff;
      pclk_in  = pclk_ff;
      pdat_in  = pdat_ff;
      pend_in  = pend_ff;

      if (line[LineOff] != seen_ff[LineOff]) begin
         seen_in[LineOff] = line[LineOff];
         if (line[LineOff]) begin
            pend_in  = 1'b1;
            armed_in = 1'b0;
            sel_in   = COLOUR_NONE;
         end
      end

      if (colour_diff) begin
         priority if (line[LineRed] != seen_ff[LineRed]) begin
            seen_in[LineRed] = line[LineRed];
            if (line[LineRed]) begin
               sel_in  = COLOUR_RED;
               pend_in = 1'b1;
            end
         end else if (line[LineGreen] != seen_ff[LineGreen]) begin
            seen_in[LineGreen] = line[LineGreen];
            if (line[LineGreen]) begin
               sel_in  = COLOUR_GREEN;
               pend_in = 1'b1;
            end
         end else begin
            seen_in[LineBlue] = line[LineBlue];
            if (line[LineBlue]) begin
               sel_in  = COLOUR_BLUE;
               pend_in = 1'b1;
            end
         end
      end else if (line[LineKnob] != seen_ff[LineKnob]) begin
         seen_in[LineKnob] = line[LineKnob];
         if (line[LineKnob] && sel_in != COLOUR_NONE) begin
            pend_in  = 1'b1;
            armed_in = !armed_ff;
            if (!armed_ff) begin
               pclk_in = req_chan.payload.enc_clk;
               pdat_in = req_chan.payload.enc_dat;
            end
         end
      end

      // level move on a falling encoder clock
      idx   = 2'(sel_in) - 2'd1;
      cur   = level_ff[idx];
      sum   = {1'b0, cur} + {1'b0, step_ff};
      if (!pdat_in) begin
         moved = sum[LevelWidth] ? LevelDark : sum[LevelWidth-1:0];
      end else begin
         moved = (cur >= step_ff) ? (cur - step_ff) : '0;
      end

      if (armed_in) begin
         if (pclk_in && !req_chan.payload.enc_clk) begin
            pend_in = 1'b1;
            if (sel_in != COLOUR_NONE) begin
               level_in[idx] = moved;
            end
         end
         pclk_in = req_chan.payload.enc_clk;
         pdat_in = req_chan.payload.enc_dat;
      end

      upd = pend_in;
      if (pend_in) begin
         pend_in = 1'b0;
         if (sel_in == COLOUR_NONE) begin
            level_in = {NumColours{LevelDark}};
         end
      end

      rsp_in.red_level     = level_in[0];
      rsp_in.green_level   = level_in[1];
      rsp_in.blue_level    = level_in[2];
      rsp_in.chosen_colour = sel_in;
      rsp_in.knob_armed    = armed_in;
      rsp_in.updated       = upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= StepReset;
         level_ff  <= {NumColours{LevelDark}};
         sel_ff    <= COLOUR_NONE;
         armed_ff  <= 1'b0;
         seen_ff   <= SeenReset;
         pclk_ff   <= 1'b0;
         pdat_ff   <= 1'b0;
         pend_ff   <= 1'b1;
         rvalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            step_ff <= csr_wdata;
         end
         if (accept) begin
            level_ff <= level_in;
            sel_ff   <= sel_in;
            armed_ff <= armed_in;
            seen_ff  <= seen_in;
            pclk_ff  <= pclk_in;
            pdat_ff  <= pdat_in;
            pend_ff  <= pend_in;
         end
         if (accept) begin
            rvalid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   a_armed_needs_colour: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (sel_ff != COLOUR_NONE))
      else $error("armed with no colour selected");

   a_dark_when_none: assert property (@(posedge clock) disable iff (reset)
      (sel_ff == COLOUR_NONE) |-> (level_ff == {NumColours{LevelDark}}))
      else $error("levels not dark with no colour selected");

   a_request_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rvalid_ff)
      else $error("accepted request left no result");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_ff.chosen_colour == sel_ff && rsp_ff.knob_armed == armed_ff))
      else $error("result disagrees with tracked state");

endmodule

`default_nettype wire

// File: dv/rgb_encoder_dimmer_control_checker.sv
module rgb_encoder_dimmer_control_checker
   import rgbdim_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_payload,
   input  logic                  csr_we,
   input  logic [LevelWidth-1:0] csr_wdata,
   output int unsigned           fail_count,
   output int unsigned           outstanding
);

   localparam colour_type ColourOf [NumColours] = '{COLOUR_RED, COLOUR_GREEN, COLOUR_BLUE};

   logic [LevelWidth-1:0] lvl [NumColours];
   colour_type            sel_q;
   logic                  armed_q;
   logic [NumLines-1:0]   seen_q;
   logic                  last_clk;
   logic                  last_dat;
   logic                  refresh_due;
   logic [LevelWidth-1:0] step_q;

   rsp_type     dimmer_outputs_due [$];
   int unsigned errors = 0;

   function automatic logic [LevelWidth-1:0] nudge(input logic [LevelWidth-1:0] v,
                                                   input logic darker);
      logic [LevelWidth:0] sum;
      sum = {1'b0, v} + {1'b0, step_q};
      if (darker) begin
         return (sum > {1'b0, LevelDark}) ? LevelDark : sum[LevelWidth-1:0];
      end
      return (v >= step_q) ? v - step_q : '0;
   endfunction

   task automatic step_dimmer(input req_type r, output rsp_type o);
      logic [NumLines-1:0] line;
      logic                hit;
      int                  k;
      int                  idx;
      line[LineRed]   = r.red_press;
      line[LineGreen] = r.green_press;
      line[LineBlue]  = r.blue_press;
      line[LineOff]   = r.off_press;
      line[LineKnob]  = r.knob_press;

      if (line[LineOff] != seen_q[LineOff]) begin
         seen_q[LineOff] = line[LineOff];
         if (line[LineOff]) begin
            refresh_due = 1'b1;
            armed_q     = 1'b0;
            sel_q       = COLOUR_NONE;
         end
      end

      // only the first changed colour line is taken; knob only if none changed
      hit = 1'b0;
      for (k = 0; k < NumColours; k++) begin
         if (!hit && line[k] != seen_q[k]) begin
            hit       = 1'b1;
            seen_q[k] = line[k];
            if (line[k]) begin
               sel_q       = ColourOf[k];
               refresh_due = 1'b1;
            end
         end
      end
      if (!hit && line[LineKnob] != seen_q[LineKnob]) begin
         seen_q[LineKnob] = line[LineKnob];
         if (line[LineKnob] && sel_q != COLOUR_NONE) begin
            refresh_due = 1'b1;
            armed_q     = !armed_q;
            if (armed_q) begin
               last_clk = r.enc_clk;
               last_dat = r.enc_dat;
            end
         end
      end

      if (armed_q) begin
         if (last_clk && !r.enc_clk) begin
            refresh_due = 1'b1;
            if (sel_q != COLOUR_NONE) begin
               idx      = int'(sel_q) - 1;
               lvl[idx] = nudge(lvl[idx], !last_dat);
            end
         end
         last_clk = r.enc_clk;
         last_dat = r.enc_dat;
      end

      o.updated = refresh_due;
      if (refresh_due) begin
         refresh_due = 1'b0;
         if (sel_q == COLOUR_NONE) begin
            lvl = '{default: LevelDark};
         end
      end
      o.red_level     = lvl[LineRed];
      o.green_level   = lvl[LineGreen];
      o.blue_level    = lvl[LineBlue];
      o.chosen_colour = sel_q;
      o.knob_armed    = armed_q;
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         lvl         = '{default: LevelDark};
         sel_q       = COLOUR_NONE;
         armed_q     = 1'b0;
         seen_q      = SeenReset;
         last_clk    = 1'b0;
         last_dat    = 1'b0;
         refresh_due = 1'b1;
         step_q      = StepReset;
         dimmer_outputs_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (dimmer_outputs_due.size() == 0) begin
               $error("result with no request waiting");
               errors++;
            end else begin
               want = dimmer_outputs_due.pop_front();
               check_field("red_level", want.red_level, got.red_level);
               check_field("green_level", want.green_level, got.green_level);
               check_field("blue_level", want.blue_level, got.blue_level);
               check_field("chosen_colour", want.chosen_colour, got.chosen_colour);
               check_field("knob_armed", want.knob_armed, got.knob_armed);
               check_field("updated", want.updated, got.updated);
            end
         end
         if (csr_we) begin
            step_q = csr_wdata;
         end
         if (req_valid && req_ready) begin
            step_dimmer(req_payload, want);
            dimmer_outputs_due.push_back(want);
         end
      end
      fail_count  <= errors;
      outstanding <= dimmer_outputs_due.size();
   end

endmodule

// File: dv/rgb_encoder_dimmer_control_tb.sv
module rgb_encoder_dimmer_control_tb;
   import rgbdim_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [LevelWidth-1:0] csr_wdata;
   int unsigned           fail_count;
   int unsigned           outstanding;

   rgbdim_chan_if #(.payload_type(req_type)) req_if ();
   rgbdim_chan_if #(.payload_type(rsp_type)) rsp_if ();

   req_type     pins;
   int unsigned burst_left    = 0;
   bit          gaps_on       = 1'b1;
   bit          hold_request  = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned phase_left    = 0;
   int unsigned ready_pct     = 100;
   int unsigned sent          = 0;
   int unsigned settings_used = 1;
   int unsigned holds_done    = 0;

   rgb_encoder_dimmer_control u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   rgb_encoder_dimmer_control_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_payload (req_if.payload),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_if.payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: random ready duty in stretches, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = 60;
         holds_done++;
         rsp_if.ready <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(10, 60);
            case ($urandom_range(0, 3))
               0: ready_pct = 100;
               1: ready_pct = 75;
               2: ready_pct = 50;
               default: ready_pct = 20;
            endcase
         end
         phase_left--;
         rsp_if.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
   end

   function automatic req_type pins_of(input bit r, input bit g, input bit b, input bit o,
                                       input bit k, input bit c, input bit d);
      req_type p;
      p.red_press   = r;
      p.green_press = g;
      p.blue_press  = b;
      p.off_press   = o;
      p.knob_press  = k;
      p.enc_clk     = c;
      p.enc_dat     = d;
      return p;
   endfunction

   task automatic push_request(input req_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = gaps_on ? $urandom_range(0, 6) : 0;
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      pins = r;
      do @(posedge clock); while (!req_if.ready);
      sent++;
   endtask

   task automatic write_step(input logic [LevelWidth-1:0] v);
      req_if.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input int unsigned n);
      req_type     nxt;
      logic [31:0] raw;
      int unsigned pick;
      repeat (n) begin
         nxt  = pins;
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 1)) nxt.enc_clk = !nxt.enc_clk;
            else nxt.enc_dat = !nxt.enc_dat;
         end else if (pick < 72) begin
            case ($urandom_range(0, 9))
               0, 1:    nxt.red_press   = !nxt.red_press;
               2, 3:    nxt.green_press = !nxt.green_press;
               4, 5:    nxt.blue_press  = !nxt.blue_press;
               6, 7, 8: nxt.knob_press  = !nxt.knob_press;
               default: nxt.off_press   = !nxt.off_press;
            endcase
         end else if (pick < 85) begin
            raw = $urandom;
            nxt = raw[$bits(req_type)-1:0];
         end
         push_request(nxt);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_we         <= 1'b0;
      csr_wdata      <= StepReset;
      pins = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, dim_step at its reset value
      push_request(pins_of(0, 0, 0, 0, 0, 0, 0));
      push_request(pins_of(0, 0, 0, 0, 1, 0, 0)); // knob with nothing selected
      push_request(pins_of(0, 0, 0, 0, 0, 0, 0));
      push_request(pins_of(1, 0, 0, 0, 0, 0, 0));
      push_request(pins_of(0, 0, 0, 0, 0, 0, 0));
      push_request(pins_of(0, 0, 0, 0, 1, 1, 0)); // arm, pins recaptured
      push_request(pins_of(0, 0, 0, 0, 0, 0, 0)); // darker at dark
      push_request(pins_of(0, 0, 0, 0, 0, 1, 1));
      push_request(pins_of(0, 0, 0, 0, 0, 0, 1)); // brighter
      push_request(pins_of(0, 0, 0, 0, 0, 1, 1));
      push_request(pins_of(0, 0, 0, 0, 0, 0, 1));
      push_request(pins_of(0, 1, 1, 0, 0, 0, 1)); // green beats blue
      push_request(pins_of(0, 0, 1, 0, 0, 0, 1));
      push_request(pins_of(0, 0, 1, 0, 0, 0, 1)); // blue taken late
      push_request(pins_of(0, 0, 1, 0, 0, 1, 1));
      push_request(pins_of(0, 0, 1, 0, 0, 0, 0));
      push_request(pins_of(0, 0, 1, 0, 1, 0, 0)); // disarm
      push_request(pins_of(0, 0, 1, 0, 0, 1, 0));
      push_request(pins_of(0, 0, 1, 0, 0, 0, 0)); // turn while disarmed
      push_request(pins_of(1, 0, 1, 1, 0, 0, 0)); // off then red together
      push_request(pins_of(0, 0, 0, 0, 0, 0, 0));
      push_request(pins_of(0, 0, 0, 1, 0, 0, 0)); // deselect
      push_request(pins_of(1, 1, 1, 0, 1, 1, 1));
      push_request(pins_of(0, 0, 0, 0, 0, 0, 0));

      // full-scale step, saturation both ways
      write_step(8'd255);
      push_request(pins_of(1, 0, 0, 0, 0, 1, 1));
      push_request(pins_of(0, 0, 0, 0, 1, 1, 1));
      push_request(pins_of(0, 0, 0, 0, 0, 0, 1));
      push_request(pins_of(0, 0, 0, 0, 0, 1, 1));
      push_request(pins_of(0, 0, 0, 0, 0, 0, 0));
      push_request(pins_of(0, 0, 0, 0, 0, 1, 0));
      push_request(pins_of(0, 0, 0, 0, 0, 0, 0));
      push_request(pins_of(0, 0, 0, 0, 0, 1, 0));
      push_request(pins_of(0, 0, 0, 0, 0, 0, 0));
      run_phase(100);

      // smallest step, receiver held off while requests keep coming
      write_step(8'd1);
      gaps_on      = 1'b0;
      hold_request = 1'b1;
      run_phase(100);
      gaps_on = 1'b1;

      write_step(8'($urandom_range(1, 255)));
      run_phase(100);

      write_step(8'($urandom_range(1, 255)));
      hold_request = 1'b1;
      run_phase(100);

      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
      $display("%0d requests checked over %0d dim_step settings, %0d long receiver hold-offs",
               sent, settings_used, holds_done);
      if (fail_count == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
